// ----- rtl/core/ssb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, codes, coefficients and the step table of the frequency
// shifter.
// ----------------------------------------------------------------------------
package ssb_pkg;

   localparam int SECTIONS   = 4;
   localparam int SEC_COUNT  = 2 * SECTIONS;
   localparam int SEC_BITS   = 3;
   localparam int STEP_BITS  = 5;
   localparam logic [STEP_BITS-1:0] LAST_STEP = 5'd18;

   // Datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_SIN_SQ = 3'd1;
   localparam logic [2:0] OP_SIN_A  = 3'd2;
   localparam logic [2:0] OP_SIN_B  = 3'd3;
   localparam logic [2:0] OP_SIN_C  = 3'd4;
   localparam logic [2:0] OP_AP     = 3'd5;
   localparam logic [2:0] OP_OUT0   = 3'd6;
   localparam logic [2:0] OP_OUT1   = 3'd7;

   // Captures of a finished sine or cosine
   localparam logic [1:0] CAP_NONE = 2'd0;
   localparam logic [1:0] CAP_SIN  = 2'd1;
   localparam logic [1:0] CAP_COS  = 2'd2;

   // Polynomial constants, Q2.30
   localparam logic [31:0] SIN_A = 32'd1686629713;
   localparam logic [31:0] SIN_B = 32'd688904866;
   localparam logic [31:0] SIN_C = 32'd76016977;

   typedef struct packed {
      logic [2:0]          op;
      logic                which;
      logic [SEC_BITS-1:0] sec;
      logic                first;
      logic                wb;
      logic [1:0]          cap;
      logic                load;
      logic                fin;
   } ssb_cmd_type;

   typedef struct packed {
      logic out_full;
   } ssb_status_type;

   // Sections 0 to 3 form the in-phase path, 4 to 7 the quadrature path.
   function automatic logic signed [17:0] ap_coef(input logic [SEC_BITS-1:0] sec);
      logic signed [17:0] c;
      case (sec)
         3'd0:    c = 18'sd62836;
         3'd1:    c = 18'sd114848;
         3'd2:    c = 18'sd128005;
         3'd3:    c = 18'sd130744;
         3'd4:    c = 18'sd21202;
         3'd5:    c = 18'sd96080;
         3'd6:    c = 18'sd123909;
         3'd7:    c = 18'sd129840;
         default: c = 18'sd0;
      endcase
      return c;
   endfunction

   function automatic ssb_cmd_type step_cmd(input logic [STEP_BITS-1:0] step);
      ssb_cmd_type c;
      c = '0;
      case (step) inside
         [5'd0:5'd7]: begin
            case (step[1:0])
               2'd0:    c.op = OP_SIN_SQ;
               2'd1:    c.op = OP_SIN_A;
               2'd2:    c.op = OP_SIN_B;
               default: c.op = OP_SIN_C;
            endcase
            c.which = step[2];
            if (step == 5'd4) begin
               c.cap = CAP_SIN;
            end
         end
         [5'd8:5'd15]: begin
            c.op    = OP_AP;
            c.sec   = step[SEC_BITS-1:0];
            c.first = (step == 5'd8) || (step == 5'd12);
            c.wb    = (step != 5'd8);
            if (step == 5'd8) begin
               c.cap = CAP_COS;
            end
         end
         5'd16: begin
            c.op = OP_OUT0;
            c.wb = 1'b1;
         end
         5'd17: begin
            c.op = OP_OUT1;
         end
         default: c.op = OP_NONE;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/ssb_if.sv -----
// ----------------------------------------------------------------------------
// ssb_req_if / ssb_rsp_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface ssb_req_if #(parameter int SAMPLE_WIDTH = 24);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_sample;
   logic signed [31:0]             phase_step;
   modport source (output valid, in_sample, phase_step, input ready);
   modport sink   (input valid, in_sample, phase_step, output ready);
endinterface

interface ssb_rsp_if #(parameter int SAMPLE_WIDTH = 24);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;
   modport source (output valid, out_sample, input ready);
   modport sink   (input valid, out_sample, output ready);
endinterface

// ----- rtl/core/ssb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssb_ctrl
// Sequencer: walks the step table for one word and issues datapath commands.
// ----------------------------------------------------------------------------
module ssb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssb_pkg::ssb_status_type status,
   output ssb_pkg::ssb_cmd_type    cmd
);
   import ssb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                 state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cnt_ff == LAST_STEP) begin
               // The result waits here until the output register is free.
               if (!status.out_full) begin
                  cmd.fin  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd    = step_cmd(cnt_ff);
               cnt_in = cnt_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_RUN) && (cnt_ff == '0))
      else $error("load did not start the sequence");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (cnt_ff != LAST_STEP) |=> (state_ff == ST_RUN))
      else $error("sequence left before its last step");
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> !status.out_full)
      else $error("result issued into a full output register");
`endif

endmodule

// ----- rtl/core/ssb_dp.sv -----
// ----------------------------------------------------------------------------
// ssb_dp
// Datapath: shared multiplier, allpass section state, sine polynomial,
// phase accumulator and output register.
// ----------------------------------------------------------------------------
module ssb_dp #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int PHASE_WIDTH  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ssb_pkg::ssb_cmd_type           cmd,
   output ssb_pkg::ssb_status_type        status,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic signed [31:0]             phase_step,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_sample
);
   import ssb_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int PW   = PHASE_WIDTH;
   localparam int MW   = (SW + 1 > 32) ? SW + 1 : 32;
   localparam int PRW  = 2 * MW;
   localparam int DW   = SW + 2;
   localparam int SHL  = (PW >= 32) ? PW - 32 : 0;
   localparam int SHR  = (PW < 32) ? 32 - PW : 0;
   localparam int XSHL = (PW < 32) ? 32 - PW : 0;
   localparam int XSHR = (PW > 32) ? PW - 32 : 0;
   localparam logic signed [PRW-1:0] HALF30 = PRW'(1) << 29;
   localparam logic signed [PRW-1:0] HALF17 = PRW'(1) << 16;
   localparam logic signed [SW-1:0]  SMAX   = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]  SMIN   = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [DW-1:0]  DMAX   = DW'(SMAX);
   localparam logic signed [DW-1:0]  DMIN   = DW'(SMIN);
   localparam logic signed [PRW:0]   FMAX   = (PRW+1)'(SMAX);
   localparam logic signed [PRW:0]   FMIN   = (PRW+1)'(SMIN);

   logic signed [SW-1:0]   x_in_ff;
   logic signed [31:0]     step_ff;
   logic [PW-1:0]          phase_ff;
   logic signed [PRW-1:0]  prod_ff;
   logic signed [PRW-1:0]  acc0_ff;
   logic signed [MW-1:0]   x2_ff;
   logic signed [31:0]     s_ff, c_ff;
   logic signed [SW-1:0]   ax_ff;
   logic [SEC_BITS-1:0]    psec_ff;
   logic signed [SW-1:0]   inph_ff, quad_ff, idly_ff;
   logic signed [SW-1:0]   xm1_ff [SEC_COUNT];
   logic signed [SW-1:0]   xm2_ff [SEC_COUNT];
   logic signed [SW-1:0]   ym1_ff [SEC_COUNT];
   logic signed [SW-1:0]   ym2_ff [SEC_COUNT];
   logic                   rsp_valid_ff;
   logic signed [SW-1:0]   out_ff;

   logic [1:0]             q, qc, qw;
   logic [PW-3:0]          frac;
   logic [29:0]            x30;
   logic [30:0]            xs, xc, xw;
   logic signed [PRW-1:0]  p_r30, p_r17;
   logic signed [MW-1:0]   r30m;
   logic signed [31:0]     v32;
   logic signed [DW-1:0]   diff;
   logic signed [SW-1:0]   y_comb, x_cur;
   logic signed [MW-1:0]   op_a, op_b;
   logic signed [PRW:0]    fsum, fr;
   logic signed [SW-1:0]   fsat;
   logic signed [63:0]     s64;
   logic [PW-1:0]          step_p;

   // Sine and cosine share the fraction; the cosine quadrant is one further.
   assign q    = phase_ff[PW-1 -: 2];
   assign qc   = q + 2'd1;
   assign frac = phase_ff[PW-3:0];
   assign x30  = 30'((64'(frac) << XSHL) >> XSHR);
   assign xs   = q[0]  ? (31'h4000_0000 - {1'b0, x30}) : {1'b0, x30};
   assign xc   = qc[0] ? (31'h4000_0000 - {1'b0, x30}) : {1'b0, x30};
   assign xw   = cmd.which ? xc : xs;
   assign qw   = (cmd.cap == CAP_COS) ? qc : q;

   assign p_r30 = (prod_ff + HALF30) >>> 30;
   assign p_r17 = (prod_ff + HALF17) >>> 17;
   assign r30m  = MW'(p_r30);
   assign v32   = 32'(p_r30);

   assign diff   = DW'(p_r17) - DW'(xm2_ff[psec_ff]);
   assign y_comb = (diff > DMAX) ? SMAX : (diff < DMIN) ? SMIN : SW'(diff);
   assign x_cur  = cmd.first ? x_in_ff : y_comb;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.op)
         OP_SIN_SQ: begin
            op_a = MW'($signed({1'b0, xw}));
            op_b = MW'($signed({1'b0, xw}));
         end
         OP_SIN_A: begin
            op_a = r30m;
            op_b = MW'($signed({1'b0, SIN_C}));
         end
         OP_SIN_B: begin
            op_a = x2_ff;
            op_b = MW'($signed({1'b0, SIN_B})) - r30m;
         end
         OP_SIN_C: begin
            op_a = MW'($signed({1'b0, xw}));
            op_b = MW'($signed({1'b0, SIN_A})) - r30m;
         end
         OP_AP: begin
            op_a = MW'(x_cur) + MW'(ym2_ff[cmd.sec]);
            op_b = MW'(ap_coef(cmd.sec));
         end
         OP_OUT0: begin
            op_a = MW'(idly_ff);
            op_b = MW'(c_ff);
         end
         OP_OUT1: begin
            op_a = MW'(quad_ff);
            op_b = MW'(s_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign fsum = (PRW+1)'(acc0_ff) + (PRW+1)'(prod_ff);
   assign fr   = (fsum + (PRW+1)'(HALF30)) >>> 30;
   assign fsat = (fr > FMAX) ? SMAX : (fr < FMIN) ? SMIN : SW'(fr);

   assign s64    = 64'(step_ff);
   assign step_p = PW'((s64 <<< SHL) >>> SHR);

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_in_ff <= in_sample;
         step_ff <= phase_step;
      end
      if (cmd.op != OP_NONE) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.op == OP_SIN_A) begin
         x2_ff <= r30m;
      end
      if (cmd.cap == CAP_SIN) begin
         s_ff <= qw[1] ? -v32 : v32;
      end
      if (cmd.cap == CAP_COS) begin
         c_ff <= qw[1] ? -v32 : v32;
      end
      if (cmd.op == OP_AP) begin
         ax_ff   <= x_cur;
         psec_ff <= cmd.sec;
      end
      if (cmd.wb && (psec_ff == SEC_BITS'(SECTIONS - 1))) begin
         inph_ff <= y_comb;
      end
      if (cmd.wb && (psec_ff == SEC_BITS'(SEC_COUNT - 1))) begin
         quad_ff <= y_comb;
      end
      if (cmd.op == OP_OUT1) begin
         acc0_ff <= prod_ff;
      end
      if (cmd.fin) begin
         out_ff <= fsat;
      end
   end

   // Filter and phase state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEC_COUNT; i++) begin
            xm1_ff[i] <= '0;
            xm2_ff[i] <= '0;
            ym1_ff[i] <= '0;
            ym2_ff[i] <= '0;
         end
         idly_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wb) begin
            xm2_ff[psec_ff] <= xm1_ff[psec_ff];
            xm1_ff[psec_ff] <= ax_ff;
            ym2_ff[psec_ff] <= ym1_ff[psec_ff];
            ym1_ff[psec_ff] <= y_comb;
         end
         if (cmd.fin) begin
            idly_ff      <= inph_ff;
            phase_ff     <= phase_ff + step_p;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign out_sample      = out_ff;

`ifndef SYNTHESIS
   a_valid_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.fin))
      else $error("result word raised without a finish command");
   a_phase_only_on_fin: assert property (@(posedge clock) disable iff (reset)
      !cmd.fin |=> $stable(phase_ff))
      else $error("phase moved outside a finish");
   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_NONE) |-> !cmd.load && !cmd.fin)
      else $error("load or finish during a datapath step");
`endif

endmodule

// ----- rtl/core/ssb_frequency_shifter.sv -----
// ----------------------------------------------------------------------------
// ssb_frequency_shifter
// Single-sideband frequency shifter built from two allpass chains in
// quadrature, a polynomial sine/cosine and a phase accumulator.
//
//   channel | role   | payload
//   req     | input  | in_sample, phase_step
//   rsp     | output | out_sample
//
// From acceptance to result, each word takes 18 operations on one
// shared multiplier (eight for sine and cosine, eight allpass sections, two
// for the mix) plus the finish. The next word is taken in the idle state
// that follows the finish.
// A new word is taken once the previous one is finished, even while its
// result still waits in the output register.
// A stalled output holds the finished sequence at its last step.
// Reset clears the section memory, the in-phase delay and the phase.
// ----------------------------------------------------------------------------
module ssb_frequency_shifter #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int PHASE_WIDTH  = 32
) (
   input logic   clock,
   input logic   reset,
   ssb_req_if.sink   req,
   ssb_rsp_if.source rsp
);
   import ssb_pkg::*;

   ssb_cmd_type    cmd;
   ssb_status_type status;

   ssb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssb_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .PHASE_WIDTH  (PHASE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_sample  (req.in_sample),
      .phase_step (req.phase_step),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .out_sample (rsp.out_sample)
   );

endmodule
